>>> hdl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLKED(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> hdl/dtp_pkg.sv
`timescale 1ns / 1ps

package dtp_pkg;

  localparam int unsigned PosW    = 5;
  localparam int unsigned YearW   = 14;
  localparam int unsigned FieldW  = 7;
  localparam int unsigned StatusW = 4;

  localparam logic [PosW-1:0] POS_SAT      = 5'd20;
  localparam logic [PosW-1:0] LEN_LONG     = 5'd19;
  localparam logic [PosW-1:0] LEN_SHORT    = 5'd10;
  localparam logic [PosW-1:0] POS_YEAR_END = 5'd4;
  localparam logic [PosW-1:0] POS_DASH_A   = 5'd4;
  localparam logic [PosW-1:0] POS_MON_END  = 5'd7;
  localparam logic [PosW-1:0] POS_DASH_B   = 5'd7;
  localparam logic [PosW-1:0] POS_DAY_END  = 5'd10;
  localparam logic [PosW-1:0] POS_T        = 5'd10;
  localparam logic [PosW-1:0] POS_HOUR_END = 5'd13;
  localparam logic [PosW-1:0] POS_COLON_A  = 5'd13;
  localparam logic [PosW-1:0] POS_MIN_END  = 5'd16;
  localparam logic [PosW-1:0] POS_COLON_B  = 5'd16;

  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [FieldW-1:0] MONTH_MAX  = 7'd12;
  localparam logic [FieldW-1:0] DAY_MAX    = 7'd31;
  localparam logic [FieldW-1:0] HOUR_MAX   = 7'd23;
  localparam logic [FieldW-1:0] MINSEC_MAX = 7'd59;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 4'd0,
    ST_LENGTH    = 4'd1,
    ST_SEPARATOR = 4'd2,
    ST_NONDIGIT  = 4'd3,
    ST_MONTH     = 4'd4,
    ST_DAY       = 4'd5,
    ST_HOUR      = 4'd6,
    ST_MINUTE    = 4'd7,
    ST_SECOND    = 4'd8
  } dtp_status_e;

  typedef struct packed {
    logic [PosW-1:0]   position;
    logic [YearW-1:0]  year;
    logic [FieldW-1:0] month;
    logic [FieldW-1:0] day;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic [FieldW-1:0] second;
    logic              separator_bad;
    logic              nondigit_seen;
  } dtp_state_t;

  function automatic logic [FieldW-1:0] dec_acc7(logic [FieldW-1:0] acc, logic [3:0] digit);
    logic [FieldW+2:0] sum;
    sum = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{(FieldW-1){1'b0}}, digit};
    return sum[FieldW-1:0];
  endfunction

  function automatic logic [YearW-1:0] dec_acc14(logic [YearW-1:0] acc, logic [3:0] digit);
    logic [YearW+2:0] sum;
    sum = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{(YearW-1){1'b0}}, digit};
    return sum[YearW-1:0];
  endfunction

endpackage

>>> hdl/datetime_text_parser.sv
// a final byte shows its result word at the output after the input register and then
// the result register; throughput: one byte per cycle while the output is not stalled;
// the path is an input register, the byte update and status logic, and the result register
// reset: rst_ni low clears both valid flags and all parse state at once
// after each final byte the parse state returns to its reset value
`timescale 1ns / 1ps
`include "assert_macros.svh"

module datetime_text_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code[7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // year[13:0], month[20:14], day[27:21], hour[34:28],
                                      // minute[41:35], second[48:42], zero fill
  output logic [4:0]  m_axis_tuser    // status[3:0], has_time[4]
);
  import dtp_pkg::*;

  logic        in_valid_q;
  logic [7:0]  char_q;
  logic        last_q;
  logic        advance;
  dtp_state_t  state_q;
  dtp_state_t  state_next;
  logic        out_valid_q;
  logic [55:0] tdata_d, tdata_q;
  logic [4:0]  tuser_d, tuser_q;
  dtp_status_e status;
  logic        long_form;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

  dtp_byte_step u_step (
    .state_i     (state_q),
    .char_code_i (char_q),
    .state_o     (state_next)
  );

  // status in priority order
  always_comb begin
    long_form = (state_next.position == LEN_LONG);
    if (!long_form && state_next.position != LEN_SHORT)            status = ST_LENGTH;
    else if (state_next.separator_bad)                              status = ST_SEPARATOR;
    else if (state_next.nondigit_seen)                              status = ST_NONDIGIT;
    else if (state_next.month > MONTH_MAX)                          status = ST_MONTH;
    else if (state_next.day > DAY_MAX)                              status = ST_DAY;
    else if (long_form && state_next.hour > HOUR_MAX)               status = ST_HOUR;
    else if (long_form && state_next.minute > MINSEC_MAX)           status = ST_MINUTE;
    else if (long_form && state_next.second > MINSEC_MAX)           status = ST_SECOND;
    else                                                            status = ST_OK;

    tdata_d = '0;
    tuser_d = {1'b0, status};
    if (status != ST_LENGTH) begin
      tuser_d[4]      = long_form;
      tdata_d[13:0]   = state_next.year;
      tdata_d[20:14]  = state_next.month;
      tdata_d[27:21]  = state_next.day;
      if (long_form) begin
        tdata_d[34:28] = state_next.hour;
        tdata_d[41:35] = state_next.minute;
        tdata_d[48:42] = state_next.second;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= in_valid_q && last_q;
      if (in_valid_q && advance) state_q <= last_q ? '0 : state_next;
    end
  end

  // word payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      char_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    if (in_valid_q && last_q && advance) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

  `ASSERT_CLKED(a_len_err_zero, clk_i, rst_ni,
    (m_axis_tvalid && m_axis_tuser[3:0] == ST_LENGTH) |-> (m_axis_tdata == '0 && !m_axis_tuser[4]),
    "length error word carries non-zero fields")
  `ASSERT_CLKED(a_short_time_zero, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tuser[4]) |-> (m_axis_tdata[55:28] == '0),
    "short form word carries time fields")
  `ASSERT_NEVER(a_pos_sat, clk_i, rst_ni, state_q.position > POS_SAT,
    "position beyond saturation")
  `ASSERT_CLKED(a_stall_blocks_input, clk_i, rst_ni,
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready,
    "input accepted while both stages are full and stalled")

endmodule

>>> hdl/dtp_byte_step.sv
`timescale 1ns / 1ps

module dtp_byte_step (
  input  dtp_pkg::dtp_state_t state_i,
  input  logic [7:0]          char_code_i,
  output dtp_pkg::dtp_state_t state_o
);
  import dtp_pkg::*;

  logic       is_digit;
  logic [3:0] digit;
  logic [7:0] diff;

  assign is_digit = (char_code_i >= CHAR_ZERO) && (char_code_i <= CHAR_NINE);
  assign diff     = char_code_i - CHAR_ZERO;
  assign digit    = diff[3:0];

  always_comb begin
    state_o = state_i;
    if (state_i.position < LEN_LONG) begin
      case (state_i.position) inside
        POS_DASH_A, POS_DASH_B: begin
          if (char_code_i != CHAR_DASH) state_o.separator_bad = 1'b1;
        end
        POS_T: begin
          if (char_code_i != CHAR_T) state_o.separator_bad = 1'b1;
        end
        POS_COLON_A, POS_COLON_B: begin
          if (char_code_i != CHAR_COLON) state_o.separator_bad = 1'b1;
        end
        default: begin
          if (!is_digit) begin
            state_o.nondigit_seen = 1'b1;
          end else if (state_i.position < POS_YEAR_END) begin
            state_o.year = dec_acc14(state_i.year, digit);
          end else if (state_i.position < POS_MON_END) begin
            state_o.month = dec_acc7(state_i.month, digit);
          end else if (state_i.position < POS_DAY_END) begin
            state_o.day = dec_acc7(state_i.day, digit);
          end else if (state_i.position < POS_HOUR_END) begin
            state_o.hour = dec_acc7(state_i.hour, digit);
          end else if (state_i.position < POS_MIN_END) begin
            state_o.minute = dec_acc7(state_i.minute, digit);
          end else begin
            state_o.second = dec_acc7(state_i.second, digit);
          end
        end
      endcase
    end
    if (state_i.position < POS_SAT) state_o.position = state_i.position + 5'd1;
  end

endmodule

>>> sim/datetime_text_parser_tb.sv
`timescale 1ns / 1ps

module datetime_text_parser_tb;
  import dtp_pkg::*;

  localparam int QuietLimit = 1000;
  localparam int LongHold   = 300;

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               has_time;
    logic [YearW-1:0]   year;
    logic [FieldW-1:0]  month;
    logic [FieldW-1:0]  day;
    logic [FieldW-1:0]  hour;
    logic [FieldW-1:0]  minute;
    logic [FieldW-1:0]  second;
  } stamp_t;

  logic        clk;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;

  // parse state mirrored by the predictor
  logic [PosW-1:0]   cur_pos;
  logic [YearW-1:0]  yr_acc;
  logic [FieldW-1:0] mon_acc, dy_acc, hr_acc, min_acc, sec_acc;
  logic              sep_err, digit_err;

  stamp_t stamp_q[$];
  stamp_t want;

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_left = 0;
  int errors = 0;
  int chars_sent = 0;
  int strings_sent = 0;
  int results_seen = 0;
  logic [8:0] codes_hit = '0;

  datetime_text_parser dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic clear_parse();
    cur_pos   = '0;
    yr_acc    = '0;
    mon_acc   = '0;
    dy_acc    = '0;
    hr_acc    = '0;
    min_acc   = '0;
    sec_acc   = '0;
    sep_err   = 1'b0;
    digit_err = 1'b0;
  endtask

  task automatic predict_char(input logic [7:0] c, input logic is_last);
    logic        is_dig;
    logic [3:0]  d;
    logic        long_form;
    dtp_status_e st;
    stamp_t      s;
    is_dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    d = is_dig ? 4'(c - CHAR_ZERO) : 4'd0;
    if (cur_pos < LEN_LONG) begin
      case (cur_pos)
        POS_DASH_A, POS_DASH_B: begin
          if (c != CHAR_DASH) sep_err = 1'b1;
        end
        POS_T: begin
          if (c != CHAR_T) sep_err = 1'b1;
        end
        POS_COLON_A, POS_COLON_B: begin
          if (c != CHAR_COLON) sep_err = 1'b1;
        end
        default: begin
          if (!is_dig) digit_err = 1'b1;
          else if (cur_pos < POS_YEAR_END) yr_acc = YearW'(yr_acc * 10 + d);
          else if (cur_pos < POS_MON_END) mon_acc = FieldW'(mon_acc * 10 + d);
          else if (cur_pos < POS_DAY_END) dy_acc = FieldW'(dy_acc * 10 + d);
          else if (cur_pos < POS_HOUR_END) hr_acc = FieldW'(hr_acc * 10 + d);
          else if (cur_pos < POS_MIN_END) min_acc = FieldW'(min_acc * 10 + d);
          else sec_acc = FieldW'(sec_acc * 10 + d);
        end
      endcase
    end
    cur_pos = (cur_pos < POS_SAT) ? PosW'(cur_pos + 1) : POS_SAT;
    if (is_last) begin
      long_form = (cur_pos == LEN_LONG);
      if (cur_pos != LEN_LONG && cur_pos != LEN_SHORT) st = ST_LENGTH;
      else if (sep_err) st = ST_SEPARATOR;
      else if (digit_err) st = ST_NONDIGIT;
      else if (mon_acc > MONTH_MAX) st = ST_MONTH;
      else if (dy_acc > DAY_MAX) st = ST_DAY;
      else if (long_form && hr_acc > HOUR_MAX) st = ST_HOUR;
      else if (long_form && min_acc > MINSEC_MAX) st = ST_MINUTE;
      else if (long_form && sec_acc > MINSEC_MAX) st = ST_SECOND;
      else st = ST_OK;
      s = '0;
      s.status = st;
      if (st != ST_LENGTH) begin
        s.has_time = long_form;
        s.year     = yr_acc;
        s.month    = mon_acc;
        s.day      = dy_acc;
        if (long_form) begin
          s.hour   = hr_acc;
          s.minute = min_acc;
          s.second = sec_acc;
        end
      end
      codes_hit[st] = 1'b1;
      stamp_q.push_back(s);
      strings_sent++;
      clear_parse();
    end
  endtask

  // called just after an edge; valid stays up until the next call or a pause
  task automatic send_char(input logic [7:0] c, input logic is_last);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    s_axis_tlast  = is_last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_char(c, is_last);
    chars_sent++;
  endtask

  task automatic send_text(input char_q_t t);
    foreach (t[i]) send_char(t[i], i == t.size() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (stamp_q.size() != 0) @(posedge clk);
  endtask

  function automatic char_q_t make_stamp(input bit long_form, input int y, input int mo,
                                         input int dy, input int h, input int mi,
                                         input int se);
    string   s;
    char_q_t q;
    if (long_form) s = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d", y, mo, dy, h, mi, se);
    else s = $sformatf("%04d-%02d-%02d", y, mo, dy);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic int rand_field(input int top);
    return ($urandom_range(9) < 8) ? $urandom_range(top) : $urandom_range(99);
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (stamp_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got tdata %h tuser %h",
                 $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = stamp_q.pop_front();
        check_field("status", want.status, m_axis_tuser[3:0]);
        check_field("has_time", want.has_time, m_axis_tuser[4]);
        check_field("year", want.year, m_axis_tdata[13:0]);
        check_field("month", want.month, m_axis_tdata[20:14]);
        check_field("day", want.day, m_axis_tdata[27:21]);
        check_field("hour", want.hour, m_axis_tdata[34:28]);
        check_field("minute", want.minute, m_axis_tdata[41:35]);
        check_field("second", want.second, m_axis_tdata[48:42]);
        check_field("fill", 0, m_axis_tdata[55:49]);
      end
    end
  end

  // result side ready, with a long hold when one is requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles, %0d results outstanding",
             $time, QuietLimit, stamp_q.size());
    $display("FAIL");
    $finish;
  end

  task automatic test_field_limits();
    send_text(make_stamp(1, 9999, 12, 31, 23, 59, 59));
    send_text(make_stamp(1, 0, 0, 0, 0, 0, 0));
    send_text(make_stamp(0, 0, 0, 0, 0, 0, 0));
    send_text(make_stamp(0, 9999, 12, 31, 0, 0, 0));
    send_text(make_stamp(1, 1234, 99, 99, 99, 99, 99));
  endtask

  task automatic test_status_codes();
    char_q_t t;
    send_text(make_stamp(0, 2024, 13, 1, 0, 0, 0));
    send_text(make_stamp(0, 2024, 1, 32, 0, 0, 0));
    send_text(make_stamp(1, 2024, 1, 1, 24, 0, 0));
    send_text(make_stamp(1, 2024, 1, 1, 0, 60, 0));
    send_text(make_stamp(1, 2024, 1, 1, 0, 0, 60));
    // wrong separators, a zero byte among them
    t = make_stamp(1, 2024, 5, 6, 7, 8, 9);
    t[POS_T] = "t";
    send_text(t);
    t = make_stamp(0, 2024, 5, 6, 0, 0, 0);
    t[POS_DASH_B] = "/";
    send_text(t);
    t = make_stamp(1, 2024, 5, 6, 7, 8, 9);
    t[POS_COLON_B] = 8'h00;
    send_text(t);
    // bytes just outside the digit range, and a zero byte in a digit
    t = make_stamp(1, 2024, 5, 6, 7, 8, 9);
    t[0] = "/";
    t[12] = ":";
    send_text(t);
    t = make_stamp(1, 2024, 5, 6, 7, 8, 9);
    t[18] = 8'h00;
    send_text(t);
    t = make_stamp(0, 2024, 19, 99, 0, 0, 0);
    t[6] = "a";
    send_text(t);
    // separator wins over non-digit
    t = make_stamp(0, 2024, 1, 1, 0, 0, 0);
    t[0] = "y";
    t[POS_DASH_A] = "x";
    send_text(t);
  endtask

  task automatic test_lengths();
    int      lens[] = '{1, 2, 9, 11, 18, 20, 21, 32, 33, 40};
    char_q_t t;
    foreach (lens[i]) begin
      t = make_stamp(1, $urandom_range(9999), 1, 2, 3, 4, 5);
      while (t.size() > lens[i]) void'(t.pop_back());
      while (t.size() < lens[i]) t.push_back(8'($urandom_range(255)));
      send_text(t);
    end
  endtask

  task automatic test_random(input int n_chars);
    int      first;
    int      kind;
    int      len;
    char_q_t t;
    first = chars_sent;
    while (chars_sent - first < n_chars) begin
      t = make_stamp(1'($urandom_range(1)), $urandom_range(9999), rand_field(12),
                     rand_field(31), rand_field(23), rand_field(59), rand_field(59));
      kind = $urandom_range(99);
      if (kind >= 70 && kind < 85) begin
        t[$urandom_range(t.size() - 1)] = 8'($urandom_range(255));
      end else if (kind >= 85 && kind < 93) begin
        len = $urandom_range(1, 26);
        while (t.size() > len) void'(t.pop_back());
        while (t.size() < len) t.push_back(8'($urandom_range(255)));
      end else if (kind >= 93) begin
        t.delete();
        repeat ($urandom_range(1, 22)) t.push_back(8'($urandom_range(255)));
      end
      send_text(t);
    end
  endtask

  task automatic test_backpressure();
    int saved_src;
    saved_src = src_idle_pct;
    src_idle_pct = 0;
    hold_left = LongHold;
    repeat (10) send_text(make_stamp(0, $urandom_range(9999), rand_field(12), rand_field(31),
                                     0, 0, 0));
    repeat (8) send_char(8'($urandom_range(255)), 1'b1);
    wait_drained();
    src_idle_pct = saved_src;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    clear_parse();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    src_idle_pct  = 17;
    sink_idle_pct = 45;
    test_field_limits();
    test_status_codes();
    test_lengths();
    test_random(60);
    wait_drained();

    src_idle_pct  = 45;
    sink_idle_pct = 17;
    test_random(60);
    test_backpressure();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random(60);
    wait_drained();
    repeat (8) @(posedge clk);

    $display("checked %0d result words from %0d strings of %0d chars, %0d of 9 status codes",
             results_seen, strings_sent, chars_sent, $countones(codes_hit));
    $display("idle mixes 17/45, 45/17 and none, plus a %0d-cycle output hold", LongHold);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
